// ----- src/iee_pkg.sv -----
// package for the infix expression evaluator
// operator codes, status codes and character constants; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package iee_pkg;
    localparam int STACK_DEPTH_DEFAULT = 32;

    localparam logic [2:0] OP_PAREN = 3'd0;
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_SUB   = 3'd2;
    localparam logic [2:0] OP_MUL   = 3'd3;
    localparam logic [2:0] OP_DIV   = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;
    localparam logic [1:0] ST_BAD  = 2'd3;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [63:0] RADIX   = 64'd10;

    function automatic logic [1:0] rank(input logic [2:0] code);
        logic [1:0] r;
        r = 2'd0;
        if (code == OP_ADD || code == OP_SUB)
            r = 2'd1;
        else if (code == OP_MUL || code == OP_DIV)
            r = 2'd2;
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- src/infix_expression_evaluator_unit.sv -----
// infix expression evaluator: top level, sequencer and shared alu
// depends on iee_pkg
`timescale 1ns / 1ps
`default_nettype none
// Takes one ASCII character per word (last_char marks the end) and gives one
// 64-bit result word with a status code at the end of each expression. A digit
// is accepted, then accumulated, with the times-ten done by shift and add. An
// open parenthesis is accepted, decoded and pushed. Any other operator, and a
// closing parenthesis, is accepted, decoded, then reads and checks the operator
// top, and repeats that for each reduction it triggers. A multiplication reduction
// runs through the shift-add multiplier, and a division reduction through the
// radix-2 divider, which is the longest path. The last character adds the
// final reductions and the steps to flush, check and present the result, and
// waits while the previous result word is still held. Both stacks are internal
// memories with a registered read port; no clearing pass is needed after
// reset. Only one character is in work at a time; in_stall is high until the
// sequencer is back in idle.
module infix_expression_evaluator_unit #(
    parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         char_code,
    input  wire logic               last_char,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [63:0]      value,
    output logic [1:0]              status
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIGIT  = 4'd1;
    localparam logic [3:0] S_TOK    = 4'd2;
    localparam logic [3:0] S_LOOP   = 4'd3;  // read operator top
    localparam logic [3:0] S_CHK    = 4'd4;  // decide on operator top
    localparam logic [3:0] S_RDB    = 4'd5;
    localparam logic [3:0] S_RDA    = 4'd6;
    localparam logic [3:0] S_CALC   = 4'd7;
    localparam logic [3:0] S_DIVI   = 4'd8;
    localparam logic [3:0] S_DIVF   = 4'd9;
    localparam logic [3:0] S_PUSHR  = 4'd10;
    localparam logic [3:0] S_FINAL  = 4'd11;
    localparam logic [3:0] S_RD0    = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;
    localparam logic [3:0] S_END    = 4'd14;
    localparam logic [3:0] S_MULI   = 4'd15;

    // kind of reduction loop running
    localparam logic [1:0] L_OPER  = 2'd0;
    localparam logic [1:0] L_CLOSE = 2'd1;
    localparam logic [1:0] L_FIN   = 2'd2;

    logic [63:0] opnd_mem [STACK_DEPTH];
    logic [2:0]  oper_mem [STACK_DEPTH];

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] ocnt_reg, ocnt_next, pcnt_reg, pcnt_next;
    logic [63:0]   acc_reg, acc_next;
    logic          pend_reg, pend_next, due_reg, due_next;
    logic [1:0]    err_reg, err_next;
    logic [7:0]    ch_reg, ch_next;
    logic          last_reg, last_next;
    logic [2:0]    code_reg, code_next;
    logic [1:0]    loop_reg, loop_next;
    logic [63:0]   a_reg, a_next, b_reg, b_next, r_reg, r_next;
    logic [63:0]   rem_reg, rem_next, q_reg, q_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic [63:0]   opnd_rd;
    logic [2:0]    oper_rd;
    logic [63:0]   val_reg, val_next;
    logic [1:0]    sts_reg, sts_next;
    logic          ov_reg, ov_next;

    // memory ports
    logic          ow_en, pw_en;
    logic [AW-1:0] ow_addr, pw_addr, or_addr, pr_addr;
    logic [63:0]   ow_data;
    logic [2:0]    pw_data;

    always_ff @(posedge clk)
    begin
        if (ow_en)
            opnd_mem[ow_addr] <= ow_data;
        if (pw_en)
            oper_mem[pw_addr] <= pw_data;
        opnd_rd <= opnd_mem[or_addr];
        oper_rd <= oper_mem[pr_addr];
    end

    logic        is_digit;
    logic [2:0]  dec_code;
    logic        dec_ok, dec_close;
    logic [64:0] sub_try;

    assign sub_try = {rem_reg[62:0], q_reg[63]} - {1'b0, b_reg};

    always_comb
    begin
        is_digit  = (ch_reg >= iee_pkg::CH_ZERO) && (ch_reg <= iee_pkg::CH_NINE);
        dec_ok    = 1'b1;
        dec_close = 1'b0;
        dec_code  = iee_pkg::OP_PAREN;
        unique case (ch_reg)
            iee_pkg::CH_PLUS:  dec_code = iee_pkg::OP_ADD;
            iee_pkg::CH_MINUS: dec_code = iee_pkg::OP_SUB;
            iee_pkg::CH_STAR:  dec_code = iee_pkg::OP_MUL;
            iee_pkg::CH_SLASH: dec_code = iee_pkg::OP_DIV;
            iee_pkg::CH_OPEN:  dec_code = iee_pkg::OP_PAREN;
            iee_pkg::CH_CLOSE: dec_close = 1'b1;
            default:           dec_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        ocnt_next = ocnt_reg;
        pcnt_next = pcnt_reg;
        acc_next = acc_reg;
        pend_next = pend_reg;
        due_next = due_reg;
        err_next = err_reg;
        ch_next = ch_reg;
        last_next = last_reg;
        code_next = code_reg;
        loop_next = loop_reg;
        a_next = a_reg;
        b_next = b_reg;
        r_next = r_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        val_next = val_reg;
        sts_next = sts_reg;
        ov_next = ov_reg;
        ow_en = 1'b0;
        pw_en = 1'b0;
        ow_addr = ocnt_reg[AW-1:0];
        pw_addr = pcnt_reg[AW-1:0];
        ow_data = acc_reg;
        pw_data = code_reg;
        or_addr = ocnt_reg[AW-1:0] - AW'(1);
        pr_addr = pcnt_reg[AW-1:0] - AW'(1);

        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ch_next = char_code;
                    last_next = last_char;
                    if (err_reg != iee_pkg::ST_OK)
                        state_next = last_char ? S_FINAL : S_IDLE;
                    else
                        state_next = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                if (is_digit)
                begin
                    if (!due_reg && !pend_reg)
                        err_next = iee_pkg::ST_BAD;
                    else
                    begin
                        // times ten as eight plus two
                        acc_next = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0}
                                 + {56'd0, ch_reg - iee_pkg::CH_ZERO};
                        pend_next = 1'b1;
                    end
                    state_next = last_reg ? S_FINAL : S_IDLE;
                end
                else if (!dec_ok)
                begin
                    err_next = iee_pkg::ST_BAD;
                    state_next = last_reg ? S_FINAL : S_IDLE;
                end
                else
                begin
                    code_next = dec_code;
                    // flush pending number
                    if (pend_reg)
                    begin
                        if (ocnt_reg >= FULL)
                            err_next = iee_pkg::ST_OVF;
                        else
                        begin
                            ow_en = 1'b1;
                            ocnt_next = ocnt_reg + CW'(1);
                        end
                        acc_next = '0;
                        pend_next = 1'b0;
                        due_next = 1'b0;
                    end
                    state_next = S_TOK;
                end
            end
            S_TOK:
            begin
                if (err_reg != iee_pkg::ST_OK)
                    state_next = last_reg ? S_FINAL : S_IDLE;
                else if (!dec_close && code_reg == iee_pkg::OP_PAREN)
                begin
                    if (!due_reg)
                        err_next = iee_pkg::ST_BAD;
                    else if (pcnt_reg >= FULL)
                        err_next = iee_pkg::ST_OVF;
                    else
                    begin
                        pw_en = 1'b1;
                        pcnt_next = pcnt_reg + CW'(1);
                    end
                    state_next = last_reg ? S_FINAL : S_IDLE;
                end
                else if (due_reg)
                begin
                    err_next = iee_pkg::ST_BAD;
                    state_next = last_reg ? S_FINAL : S_IDLE;
                end
                else
                begin
                    loop_next = dec_close ? L_CLOSE : L_OPER;
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
                state_next = S_CHK;
            S_CHK:
            begin
                if (err_reg != iee_pkg::ST_OK)
                    state_next = (loop_reg == L_FIN || last_reg) ? S_FINAL : S_IDLE;
                else if (loop_reg == L_OPER)
                begin
                    if (pcnt_reg != '0 &&
                        iee_pkg::rank(oper_rd) >= iee_pkg::rank(code_reg) &&
                        iee_pkg::rank(oper_rd) != 2'd0)
                        state_next = S_RDB;
                    else
                    begin
                        if (pcnt_reg >= FULL)
                            err_next = iee_pkg::ST_OVF;
                        else
                        begin
                            pw_en = 1'b1;
                            pcnt_next = pcnt_reg + CW'(1);
                            due_next = 1'b1;
                        end
                        state_next = last_reg ? S_FINAL : S_IDLE;
                    end
                end
                else if (loop_reg == L_CLOSE)
                begin
                    if (pcnt_reg == '0)
                    begin
                        err_next = iee_pkg::ST_BAD;
                        state_next = last_reg ? S_FINAL : S_IDLE;
                    end
                    else if (oper_rd == iee_pkg::OP_PAREN)
                    begin
                        pcnt_next = pcnt_reg - CW'(1);
                        due_next = 1'b0;
                        state_next = last_reg ? S_FINAL : S_IDLE;
                    end
                    else
                        state_next = S_RDB;
                end
                else
                begin
                    if (pcnt_reg == '0)
                    begin
                        if (ocnt_reg != CW'(1))
                            err_next = iee_pkg::ST_BAD;
                        state_next = S_RD0;
                    end
                    else if (oper_rd == iee_pkg::OP_PAREN)
                    begin
                        err_next = iee_pkg::ST_BAD;
                        state_next = S_RD0;
                    end
                    else
                        state_next = S_RDB;
                end
            end
            S_RDB:
            begin
                // reduce_top: oper_rd holds the code, opnd_rd the top operand
                if (ocnt_reg < CW'(2))
                begin
                    err_next = iee_pkg::ST_BAD;
                    state_next = S_CHK;
                end
                else
                begin
                    code_next = oper_rd;
                    b_next = opnd_rd;
                    or_addr = ocnt_reg[AW-1:0] - AW'(2);
                    pcnt_next = pcnt_reg - CW'(1);
                    state_next = S_RDA;
                end
            end
            S_RDA:
            begin
                // take the second operand as a and drop both operands from the stack
                a_next = opnd_rd;
                ocnt_next = ocnt_reg - CW'(2);
                state_next = S_CALC;
            end
            S_CALC:
            begin
                state_next = S_PUSHR;
                case (code_reg)
                    iee_pkg::OP_ADD: r_next = a_reg + b_reg;
                    iee_pkg::OP_SUB: r_next = a_reg - b_reg;
                    iee_pkg::OP_MUL:
                    begin
                        r_next = '0;
                        cnt_next = '0;
                        state_next = S_MULI;
                    end
                    iee_pkg::OP_DIV:
                    begin
                        if (b_reg == '0)
                        begin
                            err_next = iee_pkg::ST_DIV0;
                            state_next = S_CHK;
                        end
                        else
                        begin
                            neg_next = a_reg[63] ^ b_reg[63];
                            q_next = a_reg[63] ? -a_reg : a_reg;
                            b_next = b_reg[63] ? -b_reg : b_reg;
                            rem_next = '0;
                            cnt_next = '0;
                            state_next = S_DIVI;
                        end
                    end
                    default:
                    begin
                        err_next = iee_pkg::ST_BAD;
                        state_next = S_CHK;
                    end
                endcase
            end
            S_MULI:
            begin
                // shift-add, one multiplier bit per cycle
                if (b_reg[0])
                    r_next = r_reg + a_reg;
                a_next = {a_reg[62:0], 1'b0};
                b_next = {1'b0, b_reg[63:1]};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                    state_next = S_PUSHR;
            end
            S_DIVI:
            begin
                if (!sub_try[64])
                begin
                    rem_next = sub_try[63:0];
                    q_next = {q_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[62:0], q_reg[63]};
                    q_next = {q_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                    state_next = S_DIVF;
            end
            S_DIVF:
            begin
                r_next = neg_reg ? -q_reg : q_reg;
                state_next = S_PUSHR;
            end
            S_PUSHR:
            begin
                ow_data = r_reg;
                ow_en = 1'b1;
                ocnt_next = ocnt_reg + CW'(1);
                // incoming operator code is re-decoded from the held character
                code_next = dec_code;
                state_next = S_LOOP;
            end
            S_FINAL:
            begin
                // finish: flush, check, then reduce everything unless an error is set
                if (err_reg == iee_pkg::ST_OK && pend_reg)
                begin
                    if (ocnt_reg >= FULL)
                        err_next = iee_pkg::ST_OVF;
                    else
                    begin
                        ow_en = 1'b1;
                        ocnt_next = ocnt_reg + CW'(1);
                    end
                    pend_next = 1'b0;
                    due_next = 1'b0;
                    state_next = S_FINAL;
                end
                else
                begin
                    if (err_reg == iee_pkg::ST_OK && due_reg)
                        err_next = iee_pkg::ST_BAD;
                    loop_next = L_FIN;
                    state_next = (err_reg == iee_pkg::ST_OK && !due_reg) ? S_LOOP : S_RD0;
                end
            end
            S_RD0:
            begin
                or_addr = '0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg)
                begin
                    val_next = (err_reg != iee_pkg::ST_OK) ? '0 : opnd_rd;
                    sts_next = err_reg;
                    ov_next = 1'b1;
                    state_next = S_END;
                end
            end
            S_END:
            begin
                ocnt_next = '0;
                pcnt_next = '0;
                acc_next = '0;
                pend_next = 1'b0;
                err_next = iee_pkg::ST_OK;
                due_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ocnt_reg <= '0;
            pcnt_reg <= '0;
            acc_reg <= '0;
            pend_reg <= 1'b0;
            due_reg <= 1'b1;
            err_reg <= iee_pkg::ST_OK;
            ov_reg <= 1'b0;
            loop_reg <= L_OPER;
        end
        else
        begin
            state_reg <= state_next;
            ocnt_reg <= ocnt_next;
            pcnt_reg <= pcnt_next;
            acc_reg <= acc_next;
            pend_reg <= pend_next;
            due_reg <= due_next;
            err_reg <= err_next;
            ov_reg <= ov_next;
            loop_reg <= loop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg <= ch_next;
        last_reg <= last_next;
        code_reg <= code_next;
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        val_reg <= val_next;
        sts_reg <= sts_next;
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign value = val_reg;
    assign status = sts_reg;
endmodule
`default_nettype wire
